// ----- design/quad_motor_mixer_desaturate_core_assert.svh -----
// Assertion macros for the quad motor mixer core.
// Depends on nothing; included by the core module.
`ifndef QUAD_MOTOR_MIXER_DESATURATE_CORE_ASSERT_SVH
`define QUAD_MOTOR_MIXER_DESATURATE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define QMMD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define QMMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QMMD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define QMMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/qmmd_pkg.sv -----
// Shared constants and types for the quad motor mixer.
// No dependencies.
package qmmd_pkg;

    localparam int MOTOR_COUNT = 4;   // fixed quad layout, one port per motor
    localparam int ACC_W      = 32;   // Q16.16 setpoints
    localparam int ANG_W      = 16;   // Q2.14 angles
    localparam int COEF_W     = 16;   // Q4.12 coefficients
    localparam int MOT_W      = 16;   // Q1.15 motor words
    localparam int NUM_W      = 49;   // mass * (accel + gravity)
    localparam int PROD_W     = COEF_W + ACC_W;
    localparam int RAW_W      = 37;   // mixed command, Q15
    localparam int SCALE_W    = 38;   // spread and scale
    localparam int THR_DIV_BITS = 32;
    localparam int MOT_DIV_BITS = 16;
    localparam int REG_IDX_W  = 3;

    localparam logic [16:0] Q15_ONE = 17'd32768;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_ROW0  = 3'd0;
    localparam t_reg_idx REG_ROW1  = 3'd1;
    localparam t_reg_idx REG_ROW2  = 3'd2;
    localparam t_reg_idx REG_ROW3  = 3'd3;
    localparam t_reg_idx REG_MASS  = 3'd4;
    localparam t_reg_idx REG_GRAV  = 3'd5;
    localparam t_reg_idx REG_LEVEL = 3'd6;
    localparam t_reg_idx REG_TILT  = 3'd7;

endpackage

// ----- design/quad_motor_mixer_desaturate_core.sv -----
// Quad motor mixer with tilt-compensated thrust and desaturation, top level.
// Depends on qmmd_pkg and quad_motor_mixer_desaturate_core_assert.svh.
//
// One setpoint word (roll/pitch/yaw/vertical acceleration plus pitch and roll
// angle) is taken per cycle while the output buffer is not full, and one word
// of four Q1.15 motor commands and a thrust saturation flag comes out per
// input, in order. Each word passes five front stages (angle clamp and
// cosine index, cosine ROM and mass product, cosine product, tilt
// denominator, divider setup), a 32-stage restoring divider for thrust (one
// quotient bit per stage), six stages for thrust saturation, the 4x4
// allocation products, the row sums, min/max, scale and numerator setup, and a
// 16-stage divider per motor for the desaturation scale, then the floor. A
// two-word output buffer decouples the pipeline from the consumer: the whole
// pipeline advances whenever that buffer is not full, so a stalled output
// word does not block the next input until the buffer fills. The cosine ROM
// is a constant table built at elaboration (COS_TABLE_DEPTH entries, read with
// a registered output). Registers sit on an APB port at byte address 8*i with
// 64-bit data; write only while no word is in flight.
module quad_motor_mixer_desaturate_core #(
    parameter int COS_TABLE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // setpoint channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_roll_accel,
    input  logic [31:0] i_pitch_accel,
    input  logic [31:0] i_yaw_accel,
    input  logic [31:0] i_vertical_accel,
    input  logic [15:0] i_pitch_angle,
    input  logic [15:0] i_roll_angle,
    // motor channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_motor_zero,
    output logic [15:0] o_motor_one,
    output logic [15:0] o_motor_two,
    output logic [15:0] o_motor_three,
    output logic        o_thrust_saturated,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

`include "quad_motor_mixer_desaturate_core_assert.svh"

    localparam int MOTOR_COUNT = qmmd_pkg::MOTOR_COUNT;
    localparam int IDX_W = (COS_TABLE_DEPTH > 1) ? $clog2(COS_TABLE_DEPTH) : 1;
    localparam int ACC_W = qmmd_pkg::ACC_W;
    localparam int RAW_W = qmmd_pkg::RAW_W;
    localparam int SC_W  = qmmd_pkg::SCALE_W;
    localparam int TDB   = qmmd_pkg::THR_DIV_BITS;
    localparam int MDB   = qmmd_pkg::MOT_DIV_BITS;
    localparam int MW    = qmmd_pkg::MOT_W;
    localparam int SUM_W = qmmd_pkg::PROD_W + 2;
    localparam logic [63:0] SERIES_DIV [5] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90};

    // ---------------- cosine ROM, built at elaboration ----------------
    typedef logic [15:0] t_rom [COS_TABLE_DEPTH];

    function automatic t_rom build_cos_rom();
        t_rom        rom;
        logic [63:0] x, x2, term, sum;
        for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
            x    = (64'(i) << 30) / COS_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = term;
            for (int k = 0; k < 5; k++) begin
                term = ((term * x2) >> 30) / SERIES_DIV[k];
                if (k % 2 == 0) sum = sum - term;
                else            sum = sum + term;
            end
            rom[i] = 16'((sum + 64'd16384) >> 15);
        end
        return rom;
    endfunction

    localparam t_rom COS_ROM = build_cos_rom();

    // ---------------- registers ----------------
    logic [63:0] r_row [MOTOR_COUNT];
    logic [15:0] r_mass, r_grav, r_level;
    logic [14:0] r_tilt;
    logic        cfg_wr;
    qmmd_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MOTOR_COUNT; k++) r_row[k] <= '0;
            r_mass  <= 16'd256;
            r_grav  <= 16'd2511;
            r_level <= 16'd0;
            r_tilt  <= 15'd8192;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                qmmd_pkg::REG_ROW0:  r_row[0] <= pwdata;
                qmmd_pkg::REG_ROW1:  r_row[1] <= pwdata;
                qmmd_pkg::REG_ROW2:  r_row[2] <= pwdata;
                qmmd_pkg::REG_ROW3:  r_row[3] <= pwdata;
                qmmd_pkg::REG_MASS:  r_mass   <= pwdata[15:0];
                qmmd_pkg::REG_GRAV:  r_grav   <= pwdata[15:0];
                qmmd_pkg::REG_LEVEL: r_level  <= pwdata[15:0];
                qmmd_pkg::REG_TILT:  r_tilt   <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            qmmd_pkg::REG_ROW0:  prdata = r_row[0];
            qmmd_pkg::REG_ROW1:  prdata = r_row[1];
            qmmd_pkg::REG_ROW2:  prdata = r_row[2];
            qmmd_pkg::REG_ROW3:  prdata = r_row[3];
            qmmd_pkg::REG_MASS:  prdata = {48'd0, r_mass};
            qmmd_pkg::REG_GRAV:  prdata = {48'd0, r_grav};
            qmmd_pkg::REG_LEVEL: prdata = {48'd0, r_level};
            qmmd_pkg::REG_TILT:  prdata = {49'd0, r_tilt};
            default:             prdata = '0;
        endcase
    end

    // ---------------- stage types ----------------
    typedef struct packed {
        logic                    vld;
        logic signed [ACC_W-1:0] roll, pitch, yaw;
        logic [IDX_W-1:0]        idx_p, idx_r;
        logic signed [32:0]      vsum;
    } t_sa;

    typedef struct packed {
        logic                    vld;
        logic signed [ACC_W-1:0] roll, pitch, yaw;
        logic [15:0]             cp, cr;
        logic signed [qmmd_pkg::NUM_W-1:0] num;
    } t_sb;

    typedef struct packed {
        logic                    vld;
        logic signed [ACC_W-1:0] roll, pitch, yaw;
        logic [15:0]             w;
        logic signed [qmmd_pkg::NUM_W-1:0] num;
    } t_sc;

    typedef struct packed {
        logic                    vld;
        logic signed [ACC_W-1:0] roll, pitch, yaw;
        logic [15:0]             d;
        logic                    den_ok, nsign, nzero;
        logic [55:0]             nmag;
    } t_sd;

    // thrust divider stage
    typedef struct packed {
        logic                    vld;
        logic signed [ACC_W-1:0] roll, pitch, yaw;
        logic [15:0]             d, rem;
        logic [TDB-1:0]          low, q;
        logic                    ovf, den_ok, nsign, nzero;
    } t_dv;

    typedef struct packed {
        logic                    vld;
        logic signed [ACC_W-1:0] roll, pitch, yaw, thrust;
        logic                    sat;
    } t_sf;

    typedef struct packed {
        logic                    vld;
        logic [MOTOR_COUNT-1:0][3:0][qmmd_pkg::PROD_W-1:0] prod;
        logic                    sat;
    } t_sg;

    typedef struct packed {
        logic                    vld;
        logic [MOTOR_COUNT-1:0][RAW_W-1:0] raw;
        logic                    sat;
    } t_sh;

    typedef struct packed {
        logic                    vld;
        logic [MOTOR_COUNT-1:0][RAW_W-1:0] raw;
        logic signed [RAW_W-1:0] lo, hi;
        logic                    sat;
    } t_si;

    typedef struct packed {
        logic                    vld;
        logic [MOTOR_COUNT-1:0][RAW_W-1:0] raw;
        logic signed [RAW_W-1:0] lo, hi;
        logic [SC_W-1:0]         scale;
        logic                    sat;
    } t_sj;

    // motor divider stage
    typedef struct packed {
        logic                    vld;
        logic [MOTOR_COUNT-1:0][SC_W:0]  rem;
        logic [MOTOR_COUNT-1:0][MDB-1:0] q;
        logic [SC_W-1:0]         scale;
        logic                    flip, sat;
    } t_md;

    typedef struct packed {
        logic [MOTOR_COUNT-1:0][MW-1:0] motor;
        logic                    sat;
    } t_out;

    // ---------------- pipeline control ----------------
    logic [1:0] r_cnt;
    logic       en;

    assign en         = (r_cnt != 2'd2);
    assign o_in_stall = !en;

    t_sa r_a, n_a;
    t_sb r_b, n_b;
    t_sc r_c, n_c;
    t_sd r_d, n_d;
    t_dv r_dv [TDB+1];
    t_dv n_dv [TDB+1];
    t_sf r_f, n_f;
    t_sg r_g, n_g;
    t_sh r_h, n_h;
    t_si r_i, n_i;
    t_sj r_j, n_j;
    t_md r_md [MDB+1];
    t_md n_md [MDB+1];
    t_out push_word;

    // clamp |angle| to the tilt limit, halve, and scale to a ROM index
    function automatic logic [IDX_W-1:0] cos_index(logic [15:0] ang, logic [14:0] tilt);
        logic [16:0] mag;
        logic [31:0] p;
        mag = ang[15] ? 17'(-$signed({ang[15], ang})) : {1'b0, ang};
        if (mag > {2'b00, tilt}) mag = {2'b00, tilt};
        p = 32'(mag[14:1]) * 32'(COS_TABLE_DEPTH);
        return p[14 +: IDX_W];
    endfunction

    // stage A: angle index, gravity offset
    always_comb begin
        n_a.vld   = i_in_valid;
        n_a.roll  = $signed(i_roll_accel);
        n_a.pitch = $signed(i_pitch_accel);
        n_a.yaw   = $signed(i_yaw_accel);
        n_a.idx_p = cos_index(i_pitch_angle, r_tilt);
        n_a.idx_r = cos_index(i_roll_angle, r_tilt);
        n_a.vsum  = $signed({i_vertical_accel[31], i_vertical_accel})
                  + $signed({9'd0, r_grav, 8'd0});
    end

    // stage B: ROM read, mass product
    logic signed [49:0] num_full;
    always_comb begin
        num_full  = $signed({1'b0, r_mass}) * r_a.vsum;
        n_b.vld   = r_a.vld;
        n_b.roll  = r_a.roll;
        n_b.pitch = r_a.pitch;
        n_b.yaw   = r_a.yaw;
        n_b.cp    = COS_ROM[r_a.idx_p];
        n_b.cr    = COS_ROM[r_a.idx_r];
        n_b.num   = num_full[qmmd_pkg::NUM_W-1:0];
    end

    // stage C: w = cp*cr in Q1.15
    logic [31:0] cpr;
    always_comb begin
        cpr       = 32'(r_b.cp) * 32'(r_b.cr);
        n_c.vld   = r_b.vld;
        n_c.roll  = r_b.roll;
        n_c.pitch = r_b.pitch;
        n_c.yaw   = r_b.yaw;
        n_c.w     = cpr[30:15];
        n_c.num   = r_b.num;
    end

    // stage D: denominator and numerator magnitude
    logic [31:0] ww, ww2, diff;
    logic [48:0] nabs;
    always_comb begin
        ww        = 32'(r_c.w) * 32'(r_c.w);
        ww2       = {ww[30:0], 1'b0};
        diff      = ww2 - 32'h4000_0000;
        nabs      = r_c.num[48] ? 49'(-r_c.num) : 49'(r_c.num);
        n_d.vld   = r_c.vld;
        n_d.roll  = r_c.roll;
        n_d.pitch = r_c.pitch;
        n_d.yaw   = r_c.yaw;
        n_d.den_ok = (ww2 >= 32'h4000_8000);   // den15 >= 1
        n_d.d     = diff[30:15];
        n_d.nsign = r_c.num[48];
        n_d.nzero = (r_c.num == '0);
        n_d.nmag  = {nabs, 7'd0};
    end

    // stage E: divider setup; quotient past 32 bits is flagged up front.
    // Thrust divider after it: one quotient bit per stage.
    logic [23:0] rem0;
    logic [16:0] dv_t  [TDB];
    logic [16:0] dv_s  [TDB];
    logic        dv_ge [TDB];
    always_comb begin
        rem0             = r_d.nmag[55:32];
        n_dv[0].vld      = r_d.vld;
        n_dv[0].roll     = r_d.roll;
        n_dv[0].pitch    = r_d.pitch;
        n_dv[0].yaw      = r_d.yaw;
        n_dv[0].d        = r_d.d;
        n_dv[0].ovf      = (rem0 >= {8'd0, r_d.d});
        n_dv[0].rem      = n_dv[0].ovf ? 16'd0 : rem0[15:0];
        n_dv[0].low      = r_d.nmag[31:0];
        n_dv[0].q        = '0;
        n_dv[0].den_ok   = r_d.den_ok;
        n_dv[0].nsign    = r_d.nsign;
        n_dv[0].nzero    = r_d.nzero;
        for (int s = 0; s < TDB; s++) begin
            dv_t[s]  = {r_dv[s].rem, r_dv[s].low[TDB-1]};
            dv_ge[s] = (dv_t[s] >= {1'b0, r_dv[s].d});
            dv_s[s]  = dv_t[s] - {1'b0, r_dv[s].d};
            n_dv[s+1]     = r_dv[s];
            n_dv[s+1].rem = dv_ge[s] ? dv_s[s][15:0] : dv_t[s][15:0];
            n_dv[s+1].low = {r_dv[s].low[TDB-2:0], 1'b0};
            n_dv[s+1].q   = {r_dv[s].q[TDB-2:0], dv_ge[s]};
        end
    end

    // stage F: signed thrust and saturation
    t_dv dvl;
    always_comb begin
        dvl       = r_dv[TDB];
        n_f.vld   = dvl.vld;
        n_f.roll  = dvl.roll;
        n_f.pitch = dvl.pitch;
        n_f.yaw   = dvl.yaw;
        if (!dvl.den_ok) begin
            n_f.sat    = 1'b1;
            n_f.thrust = dvl.nzero ? 32'sd0 :
                         (dvl.nsign ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
        end else if (dvl.nsign) begin
            if (dvl.ovf || (dvl.q > 32'h8000_0000)) begin
                n_f.sat    = 1'b1;
                n_f.thrust = 32'sh8000_0000;
            end else begin
                n_f.sat    = 1'b0;
                n_f.thrust = $signed(32'(-dvl.q));
            end
        end else begin
            if (dvl.ovf || dvl.q[31]) begin
                n_f.sat    = 1'b1;
                n_f.thrust = 32'sh7FFF_FFFF;
            end else begin
                n_f.sat    = 1'b0;
                n_f.thrust = $signed(dvl.q);
            end
        end
    end

    // stage G: allocation products
    logic signed [ACC_W-1:0] vec [4];
    always_comb begin
        vec[0]  = r_f.pitch;
        vec[1]  = r_f.roll;
        vec[2]  = r_f.yaw;
        vec[3]  = r_f.thrust;
        n_g.vld = r_f.vld;
        n_g.sat = r_f.sat;
        for (int k = 0; k < MOTOR_COUNT; k++)
            for (int j = 0; j < 4; j++)
                n_g.prod[k][j] = $signed(r_row[k][16*j +: 16]) * vec[j];
    end

    // stage H: row sums, floor to Q15
    logic signed [SUM_W-1:0] rsum [MOTOR_COUNT];
    always_comb begin
        n_h.vld = r_g.vld;
        n_h.sat = r_g.sat;
        for (int k = 0; k < MOTOR_COUNT; k++) begin
            rsum[k] = '0;
            for (int j = 0; j < 4; j++)
                rsum[k] = rsum[k] + SUM_W'($signed(r_g.prod[k][j]));
            n_h.raw[k] = rsum[k][SUM_W-1:13];
        end
    end

    // stage I: min and max
    always_comb begin
        n_i.vld = r_h.vld;
        n_i.sat = r_h.sat;
        n_i.raw = r_h.raw;
        n_i.lo  = $signed(r_h.raw[0]);
        n_i.hi  = $signed(r_h.raw[0]);
        for (int k = 1; k < MOTOR_COUNT; k++) begin
            if ($signed(r_h.raw[k]) < n_i.lo) n_i.lo = $signed(r_h.raw[k]);
            if ($signed(r_h.raw[k]) > n_i.hi) n_i.hi = $signed(r_h.raw[k]);
        end
    end

    // stage J: spread and scale
    logic [SC_W-1:0] spread;
    always_comb begin
        spread    = SC_W'($signed({r_i.hi[RAW_W-1], r_i.hi})
                        - $signed({r_i.lo[RAW_W-1], r_i.lo}));
        n_j.vld   = r_i.vld;
        n_j.sat   = r_i.sat;
        n_j.raw   = r_i.raw;
        n_j.lo    = r_i.lo;
        n_j.hi    = r_i.hi;
        n_j.scale = (spread > SC_W'(qmmd_pkg::Q15_ONE)) ? spread
                                                        : SC_W'(qmmd_pkg::Q15_ONE);
    end

    // stage K: shift mode and per-motor numerators, all in [0, scale].
    // Motor dividers after it: floor(a * 2^15 / scale), one bit per stage.
    logic neg_lo;
    logic signed [RAW_W:0] rx, lox, hix;
    logic md_ge [MDB][MOTOR_COUNT];
    logic [SC_W:0] md_r [MDB][MOTOR_COUNT];
    always_comb begin
        neg_lo         = r_j.lo[RAW_W-1];
        lox            = {r_j.lo[RAW_W-1], r_j.lo};
        hix            = {r_j.hi[RAW_W-1], r_j.hi};
        n_md[0].vld    = r_j.vld;
        n_md[0].sat    = r_j.sat;
        n_md[0].scale  = r_j.scale;
        n_md[0].flip   = !neg_lo && ({1'b0, r_j.hi} > r_j.scale);
        n_md[0].q      = '0;
        rx             = '0;
        for (int k = 0; k < MOTOR_COUNT; k++) begin
            rx = {r_j.raw[k][RAW_W-1], r_j.raw[k]};
            if (neg_lo)
                n_md[0].rem[k] = (SC_W+1)'(rx - lox);
            else if (n_md[0].flip)
                n_md[0].rem[k] = (SC_W+1)'(hix - rx);
            else
                n_md[0].rem[k] = (SC_W+1)'(rx);
        end
        for (int s = 0; s < MDB; s++) begin
            n_md[s+1] = r_md[s];
            for (int k = 0; k < MOTOR_COUNT; k++) begin
                md_ge[s][k] = (r_md[s].rem[k] >= {1'b0, r_md[s].scale});
                md_r[s][k]  = md_ge[s][k] ? (r_md[s].rem[k] - {1'b0, r_md[s].scale})
                                          : r_md[s].rem[k];
                n_md[s+1].rem[k] = {md_r[s][k][SC_W-1:0], 1'b0};
                n_md[s+1].q[k]   = {r_md[s].q[k][MDB-2:0], md_ge[s][k]};
            end
        end
    end

    // final: undo the top-anchored shift, apply the floor
    logic [16:0] level, vmot;
    always_comb begin
        level = ({1'b0, r_level} > qmmd_pkg::Q15_ONE) ? qmmd_pkg::Q15_ONE
                                                      : {1'b0, r_level};
        push_word.sat = r_md[MDB].sat;
        vmot = '0;
        for (int k = 0; k < MOTOR_COUNT; k++) begin
            vmot = r_md[MDB].flip ? (qmmd_pkg::Q15_ONE - {1'b0, r_md[MDB].q[k]})
                                  : {1'b0, r_md[MDB].q[k]};
            if (vmot < level) vmot = level;
            push_word.motor[k] = vmot[MW-1:0];
        end
    end

    // ---------------- stage registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.vld <= 1'b0;
            r_b.vld <= 1'b0;
            r_c.vld <= 1'b0;
            r_d.vld <= 1'b0;
            r_f.vld <= 1'b0;
            r_g.vld <= 1'b0;
            r_h.vld <= 1'b0;
            r_i.vld <= 1'b0;
            r_j.vld <= 1'b0;
            for (int s = 0; s <= TDB; s++) r_dv[s].vld <= 1'b0;
            for (int s = 0; s <= MDB; s++) r_md[s].vld <= 1'b0;
        end else if (en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            r_d <= n_d;
            r_f <= n_f;
            r_g <= n_g;
            r_h <= n_h;
            r_i <= n_i;
            r_j <= n_j;
            for (int s = 0; s <= TDB; s++) r_dv[s] <= n_dv[s];
            for (int s = 0; s <= MDB; s++) r_md[s] <= n_md[s];
        end
    end

    // ---------------- two-word output buffer ----------------
    t_out r_buf [2];
    logic r_wp, r_rp;
    logic push, pop;
    logic [1:0] n_cnt;

    assign push = en && r_md[MDB].vld;
    assign pop  = o_out_valid && !i_out_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) n_cnt = r_cnt + 2'd1;
        if (pop && !push) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_buf[r_wp] <= push_word;
    end

    assign o_out_valid        = (r_cnt != 2'd0);
    assign o_motor_zero       = r_buf[r_rp].motor[0];
    assign o_motor_one        = r_buf[r_rp].motor[1];
    assign o_motor_two        = r_buf[r_rp].motor[2];
    assign o_motor_three      = r_buf[r_rp].motor[3];
    assign o_thrust_saturated = r_buf[r_rp].sat;

    // ---------------- assertions ----------------
    `QMMD_ASSERT_IMPLIES(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= 2'd2, "buffer count overrun")
    `QMMD_ASSERT_IMPLIES(a_motor_max, i_clk, i_rst_n, o_out_valid, (o_motor_zero <= 16'd32768) && (o_motor_one <= 16'd32768) && (o_motor_two <= 16'd32768) && (o_motor_three <= 16'd32768), "motor above one")
    `QMMD_ASSERT_IMPLIES(a_motor_floor, i_clk, i_rst_n, o_out_valid, ({1'b0, o_motor_zero} >= level) && ({1'b0, o_motor_one} >= level) && ({1'b0, o_motor_two} >= level) && ({1'b0, o_motor_three} >= level), "motor below floor")
    `QMMD_ASSERT_NEXT(a_full_hold, i_clk, i_rst_n, (r_cnt == 2'd2) && i_out_stall, r_cnt == 2'd2, "full buffer changed under stall")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for quad_motor_mixer_desaturate_core: drives setpoint words,
// predicts motor words in SystemVerilog and compares them in order.
// Depends on qmmd_pkg and the core RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 1024;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PIPE_DRAIN = 80;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_roll_accel, i_pitch_accel, i_yaw_accel, i_vertical_accel;
    logic [15:0] i_pitch_angle, i_roll_angle;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_motor_zero, o_motor_one, o_motor_two, o_motor_three;
    logic        o_thrust_saturated;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    quad_motor_mixer_desaturate_core dut (.*);

    // Expected motor word: four motor commands plus the saturation flag
    typedef struct packed {
        logic [15:0] m0, m1, m2, m3;
        logic        sat;
    } t_motor_word;

    t_motor_word motor_q[$];

    // Shadow copy of the register file
    logic [63:0] mix_rows [4];
    logic [15:0] mass_q88, grav_q88, floor_q15;
    logic [14:0] tilt_q214;
    logic [31:0] cos_q15 [TABLE_DEPTH];

    int errors, mismatches, words_in, words_out, sat_seen, idle_cycles;
    bit sender_bursty, receiver_hold, receiver_random;
    int hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cosine table rebuilt with the same integer series as the hardware ROM
    task automatic build_cos_table();
        longint unsigned x, x2, term, total;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            x = (longint'(i) << 30) / TABLE_DEPTH;
            x2 = (x * x) >> 30;
            term = 64'd1 << 30;
            total = term;
            for (int k = 1; k <= 5; k++) begin
                term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
                if (k % 2 == 1) total -= term;
                else total += term;
            end
            cos_q15[i] = 32'((total + (64'd1 << 14)) >> 15);
        end
    endtask

    function automatic longint clamp_tilt(longint a);
        longint t;
        t = longint'(tilt_q214);
        if (a > t) return t;
        if (a < -t) return -t;
        return a;
    endfunction

    function automatic longint half_angle_cos(longint a);
        longint unsigned h, idx;
        h = longint'(a < 0 ? -a : a) >> 1;
        idx = (h * TABLE_DEPTH) >> 14;
        if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
        return longint'(cos_q15[idx]);
    endfunction

    function automatic longint floor_div8k(longint x);
        if (x >= 0) return x >>> 13;
        return -((-x + 8191) >>> 13);
    endfunction

    // Mixer prediction for one setpoint word
    function automatic t_motor_word mix_motors(logic [31:0] roll_a, pitch_a, yaw_a, vert_a,
                                               logic [15:0] pitch_ang, roll_ang);
        t_motor_word w;
        longint cp, cr, cw, den30, den15, num, thrust, acc, lo, hi, spread, scale, lvl, v;
        longint vec [4];
        longint raw [4];
        logic [15:0] outs [4];
        logic sat;
        cp = half_angle_cos(clamp_tilt(longint'($signed(pitch_ang))));
        cr = half_angle_cos(clamp_tilt(longint'($signed(roll_ang))));
        cw = (cp * cr) >>> 15;
        den30 = 2 * cw * cw - (64'sd1 <<< 30);
        den15 = den30 > 0 ? (den30 >>> 15) : 0;
        num = longint'(mass_q88) * (longint'($signed(vert_a)) + (longint'(grav_q88) <<< 8));
        sat = 1'b0;
        if (den15 <= 0) begin
            sat = 1'b1;
            thrust = num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
        end else begin
            thrust = (num * 128) / den15;
            if (thrust > 64'sd2147483647) begin
                thrust = 64'sd2147483647;
                sat = 1'b1;
            end
            if (thrust < -64'sd2147483648) begin
                thrust = -64'sd2147483648;
                sat = 1'b1;
            end
        end
        vec[0] = longint'($signed(pitch_a));
        vec[1] = longint'($signed(roll_a));
        vec[2] = longint'($signed(yaw_a));
        vec[3] = thrust;
        for (int k = 0; k < 4; k++) begin
            acc = 0;
            for (int j = 0; j < 4; j++)
                acc += longint'($signed(mix_rows[k][16*j +: 16])) * vec[j];
            raw[k] = floor_div8k(acc);
        end
        lo = raw[0];
        hi = raw[0];
        for (int k = 1; k < 4; k++) begin
            if (raw[k] > hi) hi = raw[k];
            if (raw[k] < lo) lo = raw[k];
        end
        spread = hi - lo;
        scale = spread > 32768 ? spread : 32768;
        lvl = floor_q15 > 16'd32768 ? 32768 : longint'(floor_q15);
        for (int k = 0; k < 4; k++) begin
            if (lo < 0) v = ((raw[k] - lo) * 32768) / scale;
            else if (hi > scale) v = 32768 - ((hi - raw[k]) * 32768) / scale;
            else v = (raw[k] * 32768) / scale;
            if (v < lvl) v = lvl;
            outs[k] = v[15:0];
        end
        w.m0 = outs[0];
        w.m1 = outs[1];
        w.m2 = outs[2];
        w.m3 = outs[3];
        w.sat = sat;
        return w;
    endfunction

    // Register write: setup then access cycle, shadow updated alongside
    task automatic write_reg(qmmd_pkg::t_reg_idx idx, logic [63:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx) inside
            qmmd_pkg::REG_ROW0, qmmd_pkg::REG_ROW1,
            qmmd_pkg::REG_ROW2, qmmd_pkg::REG_ROW3: mix_rows[idx] = value;
            qmmd_pkg::REG_MASS:  mass_q88 = value[15:0];
            qmmd_pkg::REG_GRAV:  grav_q88 = value[15:0];
            qmmd_pkg::REG_LEVEL: floor_q15 = value[15:0];
            qmmd_pkg::REG_TILT:  tilt_q214 = value[14:0];
            default: ;
        endcase
    endtask

    // Drive one setpoint word and hold it until accepted
    task automatic send_setpoint(logic [31:0] ra, pa, ya, va, logic [15:0] pang, rang);
        i_in_valid <= 1'b1;
        i_roll_accel <= ra;
        i_pitch_accel <= pa;
        i_yaw_accel <= ya;
        i_vertical_accel <= va;
        i_pitch_angle <= pang;
        i_roll_angle <= rang;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        motor_q.push_back(mix_motors(ra, pa, ya, va, pang, rang));
        words_in++;
        // bursty sender: random gap after some words
        if (sender_bursty && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
    endtask

    task automatic drain_pipe();
        end_burst();
        while (motor_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // Random setpoint; small accelerations most of the time so mixing stays in range
    task automatic send_random();
        logic [31:0] a [4];
        for (int j = 0; j < 4; j++) begin
            case ($urandom_range(0, 3))
                0: a[j] = $urandom;
                1: a[j] = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
                default: a[j] = 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
            endcase
        end
        send_setpoint(a[0], a[1], a[2], a[3], 16'($urandom), 16'($urandom));
    endtask

    // Quad-X style coefficients with random perturbation
    function automatic logic [63:0] random_row();
        if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
        return {16'($urandom_range(0, 8192)), 16'($signed($urandom_range(0, 8192)) - 4096),
                16'($signed($urandom_range(0, 8192)) - 4096),
                16'($signed($urandom_range(0, 8192)) - 4096)};
    endfunction

    task automatic test_defaults();
        // reset rows are zero: every motor sits at the floor
        send_setpoint(32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
        send_setpoint(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h7fffffff, 16'h7fff, 16'h8000);
        drain_pipe();
    endtask

    task automatic test_directed();
        write_reg(qmmd_pkg::REG_ROW0, {16'h1000, 16'h1000, 16'h1000, 16'h1000});
        write_reg(qmmd_pkg::REG_ROW1, {16'h1000, 16'hf000, 16'hf000, 16'h1000});
        write_reg(qmmd_pkg::REG_ROW2, {16'h1000, 16'h1000, 16'hf000, 16'hf000});
        write_reg(qmmd_pkg::REG_ROW3, {16'h1000, 16'hf000, 16'h1000, 16'hf000});
        // level and hover
        send_setpoint(32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
        // field extremes
        send_setpoint(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h7fff);
        send_setpoint(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000);
        send_setpoint(32'hffffffff, 32'h00000001, 32'h0, 32'hffff0000, 16'hffff, 16'h0001);
        // thrust cancels out: zero numerator
        send_setpoint(32'h0, 32'h0, 32'h0, -32'sd2511 * 256, 16'h0, 16'h0);
        // small spread that needs no scaling
        send_setpoint(32'h100, 32'h200, 32'h300, 32'h0, 16'h1000, 16'hf000);
        drain_pipe();
        // tilt register at its top: denominator goes non-positive
        write_reg(qmmd_pkg::REG_TILT, 15'h7fff);
        send_setpoint(32'h0, 32'h0, 32'h0, 32'h10000, 16'h7fff, 16'h7fff);
        send_setpoint(32'h0, 32'h0, 32'h0, 32'h80000000, 16'h8000, 16'h7000);
        send_setpoint(32'h0, 32'h0, 32'h0, -32'sd2511 * 256, 16'h7fff, 16'h8000);
        drain_pipe();
        // thrust overflow with big mass, floor above one, zero tilt
        write_reg(qmmd_pkg::REG_MASS, 16'hffff);
        write_reg(qmmd_pkg::REG_GRAV, 16'hffff);
        write_reg(qmmd_pkg::REG_LEVEL, 16'hffff);
        write_reg(qmmd_pkg::REG_TILT, 15'h0);
        send_setpoint(32'h0, 32'h0, 32'h0, 32'h7fffffff, 16'h4000, 16'hc000);
        send_setpoint(32'h12345, 32'h0, 32'hfff00000, 32'h80000000, 16'h0, 16'h0);
        drain_pipe();
        write_reg(qmmd_pkg::REG_MASS, 16'h0);
        write_reg(qmmd_pkg::REG_GRAV, 16'h0);
        write_reg(qmmd_pkg::REG_LEVEL, 16'd32768);
        send_setpoint(32'h1000, 32'h2000, 32'h3000, 32'h4000, 16'h100, 16'h200);
        drain_pipe();
        // a floor just below one
        write_reg(qmmd_pkg::REG_LEVEL, 16'd32767);
        write_reg(qmmd_pkg::REG_TILT, 15'd25735);
        write_reg(qmmd_pkg::REG_MASS, 16'd256);
        write_reg(qmmd_pkg::REG_GRAV, 16'd2511);
        send_setpoint(32'h1000, 32'hffff0000, 32'h0, 32'h0, 16'h2000, 16'he000);
        drain_pipe();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 6; phase++) begin
            for (int k = 0; k < 4; k++) write_reg(qmmd_pkg::t_reg_idx'(k), random_row());
            write_reg(qmmd_pkg::REG_MASS,
                      phase == 0 ? 16'h0 : 16'($urandom_range(64, 2048)));
            write_reg(qmmd_pkg::REG_GRAV,
                      phase == 1 ? 16'hffff : 16'($urandom_range(0, 4096)));
            write_reg(qmmd_pkg::REG_LEVEL,
                      phase == 2 ? 16'h0 : 16'($urandom_range(0, 40000)));
            write_reg(qmmd_pkg::REG_TILT,
                      phase == 3 ? 15'h7fff : 15'($urandom_range(0, 25735)));
            sender_bursty = (phase % 2 == 0);
            for (int n = 0; n < 200; n++) send_random();
            drain_pipe();
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering words
    task automatic test_backpressure();
        hold_cycles = 300;
        receiver_hold = 1'b1;
        sender_bursty = 1'b0;
        for (int n = 0; n < 150; n++) send_random();
        end_burst();
        wait (!receiver_hold);
        drain_pipe();
    endtask

    // No idling on either side
    task automatic test_full_rate();
        receiver_random = 1'b0;
        sender_bursty = 1'b0;
        for (int n = 0; n < 200; n++) send_random();
        drain_pipe();
        receiver_random = 1'b1;
    endtask

    // Receiver stall pattern: random runs, forced long hold on request
    initial begin
        int run;
        i_out_stall = 1'b0;
        run = 0;
        forever begin
            @(posedge i_clk);
            if (receiver_hold) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles - 1) @(posedge i_clk);
                i_out_stall <= 1'b0;
                receiver_hold = 1'b0;
            end else if (!receiver_random) begin
                i_out_stall <= 1'b0;
            end else if (run > 0) begin
                run--;
            end else begin
                i_out_stall <= ($urandom_range(0, 2) == 0);
                run = $urandom_range(0, 6);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_motor_word got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_motor_zero, o_motor_one, o_motor_two, o_motor_three, o_thrust_saturated};
            words_out++;
            if (motor_q.size() == 0) begin
                errors++;
                $display("unexpected motor word %h", got);
            end else begin
                want = motor_q.pop_front();
                if (want.sat) sat_seen++;
                if (got !== want) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("motor word %0d mismatch: expected %h %h %h %h sat %b, got %h %h %h %h sat %b",
                                 words_out, want.m0, want.m1, want.m2, want.m3, want.sat,
                                 got.m0, got.m1, got.m2, got.m3, got.sat);
                end
            end
        end
    end

    // Watchdog: cycles with no accepted word on either channel and no register access
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("quad_motor_mixer_desaturate_core test failed");
            $finish;
        end
    end

    initial begin
        errors = 0;
        mismatches = 0;
        words_in = 0;
        words_out = 0;
        sat_seen = 0;
        idle_cycles = 0;
        sender_bursty = 1'b1;
        receiver_hold = 1'b0;
        receiver_random = 1'b1;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        {i_roll_accel, i_pitch_accel, i_yaw_accel, i_vertical_accel} = '0;
        {i_pitch_angle, i_roll_angle} = '0;
        {psel, penable, pwrite} = '0;
        paddr = '0;
        pwdata = '0;
        for (int k = 0; k < 4; k++) mix_rows[k] = '0;
        mass_q88 = 16'd256;
        grav_q88 = 16'd2511;
        floor_q15 = 16'd0;
        tilt_q214 = 15'd8192;
        build_cos_table();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_directed();
        test_backpressure();
        test_full_rate();
        test_random_settings();
        $display("Sent %0d setpoint words and checked %0d motor words (%0d saturated thrust)",
                 words_in, words_out, sat_seen);
        $display("across reset defaults, directed extremes, stalls and six register settings");
        if (errors == 0 && motor_q.size() == 0)
            $display("quad_motor_mixer_desaturate_core test passed");
        else
            $display("quad_motor_mixer_desaturate_core test failed");
        $finish;
    end
endmodule
